// ===== hdl/sffd_pkg.sv =====
// Shared types and constants for the SPI fixed-frame deframer.
`default_nettype none
package sffd_pkg;

   localparam logic [7:0] HDR_BYTE = 8'hA5;
   localparam logic [7:0] TRL_BYTE = 8'h5A;

   localparam int unsigned FRAME_DEPTH = 10;
   localparam int unsigned VAL_COUNT   = 4;

   localparam logic [3:0] SMALL_LAST = 4'd5;
   localparam logic [3:0] WIDE_LAST  = 4'd9;

   localparam logic CSR_IDX_FRAME_MODE = 1'b0;

   typedef enum logic [1:0] {
      REQ_RX_BYTE    = 2'd0,
      REQ_RESTART    = 2'd1,
      REQ_TAKE_SMALL = 2'd2,
      REQ_TAKE_WIDE  = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic clear;
      logic mode;
   } cfg_ctl_type;

   typedef struct packed {
      logic        got_frame;
      logic [15:0] word0;
      logic [15:0] word1;
      logic [15:0] word2;
      logic [15:0] word3;
   } rsp_beat_type;

endpackage
`default_nettype wire

// ===== hdl/sffd_csr.sv =====
// APB-style register port holding the frame mode.
`default_nettype none
module sffd_csr
   import sffd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output cfg_ctl_type      cfg
);

   logic mode_ff;
   logic mode_in;
   logic wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == CSR_IDX_FRAME_MODE);

   always_comb begin
      mode_in = mode_ff;
      if (wr_hit) begin
         mode_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == CSR_IDX_FRAME_MODE) begin
         csr_prdata = {31'd0, mode_ff};
      end
   end

   assign cfg = '{clear: wr_hit, mode: mode_ff};

endmodule
`default_nettype wire

// ===== hdl/sffd_frame.sv =====
// Frame collector: byte count, frame store, header/trailer check and take logic.
`default_nettype none
module sffd_frame
   import sffd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_ctl_type  cfg,
   input  wire logic         item_valid,
   input  wire req_kind_type item_kind,
   input  wire logic [7:0]   item_data,
   output rsp_beat_type      result
);

   logic [3:0]  count_ff, count_in;
   logic [7:0]  store_ff [FRAME_DEPTH];
   logic [7:0]  store_in [FRAME_DEPTH];
   logic [7:0]  small_ff [VAL_COUNT];
   logic [7:0]  small_in [VAL_COUNT];
   logic [15:0] wide_ff  [VAL_COUNT];
   logic [15:0] wide_in  [VAL_COUNT];
   logic        small_rdy_ff, small_rdy_in;
   logic        wide_rdy_ff, wide_rdy_in;
   logic [3:0]  last_pos;
   logic        frame_good;

   assign last_pos   = cfg.mode ? WIDE_LAST : SMALL_LAST;
   assign frame_good = (store_ff[0] == HDR_BYTE) && (item_data == TRL_BYTE);

   always_comb begin
      count_in     = count_ff;
      store_in     = store_ff;
      small_in     = small_ff;
      wide_in      = wide_ff;
      small_rdy_in = small_rdy_ff;
      wide_rdy_in  = wide_rdy_ff;
      result       = '0;
      if (cfg.clear) begin
         count_in     = 4'd0;
         small_rdy_in = 1'b0;
         wide_rdy_in  = 1'b0;
      end else if (item_valid) begin
         unique case (item_kind)
            REQ_RX_BYTE: begin
               for (int i = 0; i < FRAME_DEPTH; i++) begin
                  if (count_ff == 4'(i)) begin
                     store_in[i] = item_data;
                  end
               end
               if (count_ff >= last_pos) begin
                  count_in = 4'd0;
                  if (frame_good) begin
                     if (!cfg.mode) begin
                        for (int i = 0; i < VAL_COUNT; i++) begin
                           small_in[i] = store_ff[1 + i];
                        end
                        small_rdy_in = 1'b1;
                     end else begin
                        for (int i = 0; i < VAL_COUNT; i++) begin
                           wide_in[i] = {store_ff[2 + 2 * i], store_ff[1 + 2 * i]};
                        end
                        wide_rdy_in = 1'b1;
                     end
                  end
               end else begin
                  count_in = count_ff + 4'd1;
               end
            end
            REQ_RESTART: begin
               count_in = 4'd0;
            end
            REQ_TAKE_SMALL: begin
               if (small_rdy_ff) begin
                  result.got_frame = 1'b1;
                  result.word0     = {8'd0, small_ff[0]};
                  result.word1     = {8'd0, small_ff[1]};
                  result.word2     = {8'd0, small_ff[2]};
                  result.word3     = {8'd0, small_ff[3]};
                  small_rdy_in     = 1'b0;
               end
            end
            REQ_TAKE_WIDE: begin
               if (wide_rdy_ff) begin
                  result.got_frame = 1'b1;
                  result.word0     = wide_ff[0];
                  result.word1     = wide_ff[1];
                  result.word2     = wide_ff[2];
                  result.word3     = wide_ff[3];
                  wide_rdy_in      = 1'b0;
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= 4'd0;
         small_rdy_ff <= 1'b0;
         wide_rdy_ff  <= 1'b0;
      end else begin
         count_ff     <= count_in;
         small_rdy_ff <= small_rdy_in;
         wide_rdy_ff  <= wide_rdy_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
      small_ff <= small_in;
      wide_ff  <= wide_in;
   end

endmodule
`default_nettype wire

// ===== hdl/spi_fixed_frame_deframer_core.sv =====
// Top level of the SPI fixed-frame deframer.
//
// Usage: each req beat carries req_type and req_rx_data. A received byte
// (type 0) adds to the current frame; a restart (type 1) zeroes the byte
// count; a take (type 2 byte frame, type 3 word frame) returns the stored
// values when the matching ready flag is set and clears it. Every req beat
// yields exactly one rsp beat; rsp_got_frame is 0 with all words 0 unless a
// take found fresh data.
// Pipeline: a req beat is held in the input register and is then moved into
// the rsp register, from which its rsp beat is presented. Throughput is one
// beat per cycle while rsp_ready keeps taking rsp beats, set by the single
// input register feeding the single rsp register.
// A stalled rsp_ready holds the rsp register; one more req beat can be held
// in the input register, then req_ready drops until the rsp beat is taken.
// Reset empties both registers, zeroes the byte count, clears both ready
// flags and sets frame_mode to 0. Writing frame_mode (csr offset 0) clears
// the flags and the byte count; stored values are kept.
`default_nettype none
module spi_fixed_frame_deframer_core
   import sffd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_rx_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_got_frame,
   output logic [15:0]      rsp_word0,
   output logic [15:0]      rsp_word1,
   output logic [15:0]      rsp_word2,
   output logic [15:0]      rsp_word3,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cfg_ctl_type  cfg;
   logic         s1_valid_ff, s1_valid_in;
   req_kind_type s1_kind_ff;
   logic [7:0]   s1_data_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_ff;
   rsp_beat_type result;
   logic         out_free;
   logic         advance;
   logic         req_fire;

   sffd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sffd_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (advance),
      .item_kind  (s1_kind_ff),
      .item_data  (s1_data_ff),
      .result     (result)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff <= req_kind_type'(req_type);
         s1_data_ff <= req_rx_data;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_got_frame = rsp_ff.got_frame;
   assign rsp_word0     = rsp_ff.word0;
   assign rsp_word1     = rsp_ff.word1;
   assign rsp_word2     = rsp_ff.word2;
   assign rsp_word3     = rsp_ff.word3;

endmodule
`default_nettype wire

// ===== hdl/sffd_checker.sv =====
// Port-level assertions for the SPI fixed-frame deframer and their bind.
`default_nettype none
module sffd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_got_frame,
   input wire logic [15:0] rsp_word0,
   input wire logic [15:0] rsp_word1,
   input wire logic [15:0] rsp_word2,
   input wire logic [15:0] rsp_word3
);

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp beat present right after reset");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req stalled while rsp side can move");

   a_empty_take_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_got_frame) |->
         (rsp_word0 == 16'd0 && rsp_word1 == 16'd0 &&
          rsp_word2 == 16'd0 && rsp_word3 == 16'd0))
      else $error("nonzero words on a beat without a frame");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_got_frame) && $stable(rsp_word0) &&
          $stable(rsp_word1) && $stable(rsp_word2) && $stable(rsp_word3)))
      else $error("stalled rsp beat changed");

endmodule

bind spi_fixed_frame_deframer_core sffd_checker u_sffd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_got_frame (rsp_got_frame),
   .rsp_word0     (rsp_word0),
   .rsp_word1     (rsp_word1),
   .rsp_word2     (rsp_word2),
   .rsp_word3     (rsp_word3)
);
`default_nettype wire
